// ===== src/hrbd_pkg.sv =====
`default_nettype none
package hrbd_pkg;

   localparam int COUNT_BITS = 32;
   localparam int WIDE_BITS  = COUNT_BITS + 4;

   localparam logic [4:0] LEN_KEY_LEN    = 5'd16;
   localparam logic [4:0] LEN_VALUE_DONE = 5'd17;
   localparam logic [4:0] CHK_KEY_LEN    = 5'd26;

   localparam logic [8*16-1:0] LEN_KEY = "Content-Length: ";
   localparam logic [8*26-1:0] CHK_KEY = "Transfer-Encoding: chunked";

   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   typedef enum logic [3:0] {
      PH_HEADER,
      PH_LEN_BODY,
      PH_SIZE_DIGITS,
      PH_SIZE_TAIL,
      PH_CHUNK_DATA,
      PH_SKIP_CR,
      PH_SKIP_LF,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      MODE_NONE    = 2'd0,
      MODE_LENGTH  = 2'd1,
      MODE_CHUNKED = 2'd2
   } mode_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] body_byte;
      logic       has_byte;
      logic       end_of_body;
      mode_type   framing_mode;
   } res_type;

   typedef struct packed {
      logic [1:0] cnt;
      logic       hit;
   } crlf_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } digit_type;

   function automatic logic [7:0] len_key_byte(logic [4:0] i);
      logic [7:0] b;
      b = '0;
      if (i < LEN_KEY_LEN) begin
         b = LEN_KEY[8*(int'(LEN_KEY_LEN) - 1 - int'(i)) +: 8];
      end
      return b;
   endfunction

   function automatic logic [7:0] chk_key_byte(logic [4:0] i);
      logic [7:0] b;
      b = '0;
      if (i < CHK_KEY_LEN) begin
         b = CHK_KEY[8*(int'(CHK_KEY_LEN) - 1 - int'(i)) +: 8];
      end
      return b;
   endfunction

   function automatic logic [4:0] key_step(logic [4:0] prog, logic [7:0] key_ch,
                                           logic [7:0] first_ch, logic [7:0] c);
      logic [4:0] n;
      if (key_ch == c) begin
         n = prog + 5'd1;
      end else if (first_ch == c) begin
         n = 5'd1;
      end else begin
         n = 5'd0;
      end
      return n;
   endfunction

   function automatic digit_type dec_value(logic [7:0] c);
      digit_type d;
      d.ok  = (c >= "0") && (c <= "9");
      d.val = 4'(c - "0");
      return d;
   endfunction

   function automatic digit_type hex_value(logic [7:0] c);
      digit_type d;
      d = '0;
      if ((c >= "0") && (c <= "9")) begin
         d.ok  = 1'b1;
         d.val = 4'(c - "0");
      end else if ((c >= "a") && (c <= "f")) begin
         d.ok  = 1'b1;
         d.val = 4'(c - "a" + 8'd10);
      end else if ((c >= "A") && (c <= "F")) begin
         d.ok  = 1'b1;
         d.val = 4'(c - "A" + 8'd10);
      end
      return d;
   endfunction

   // two-crlf tracker in the header, single crlf on size lines
   function automatic crlf_type crlf_next(logic [1:0] cnt, logic [7:0] c, logic full);
      crlf_type r;
      r.cnt = 2'd0;
      r.hit = 1'b0;
      if (c == CHAR_CR) begin
         r.cnt = (cnt == 2'd2 && full) ? 2'd3 : 2'd1;
      end else if (c == CHAR_LF) begin
         if (cnt == 2'd1) begin
            if (full) begin
               r.cnt = 2'd2;
            end else begin
               r.hit = 1'b1;
            end
         end else if (cnt == 2'd3 && full) begin
            r.hit = 1'b1;
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== src/hrbd_acc.sv =====
`default_nettype none
module hrbd_acc (
   input  wire logic [hrbd_pkg::COUNT_BITS-1:0] acc,
   input  wire logic                            is_hex,
   input  wire logic [3:0]                      digit,
   output logic      [hrbd_pkg::COUNT_BITS-1:0] sum
);
   import hrbd_pkg::*;

   logic [WIDE_BITS-1:0] acc_w;
   logic [WIDE_BITS-1:0] scaled;
   logic [WIDE_BITS-1:0] total;

   assign acc_w  = WIDE_BITS'(acc);
   assign scaled = is_hex ? (acc_w << 4) : ((acc_w << 3) + (acc_w << 1));
   assign total  = scaled + WIDE_BITS'(digit);

   // saturate at all ones
   assign sum = (total[WIDE_BITS-1:COUNT_BITS] != '0) ? '1 : total[COUNT_BITS-1:0];

endmodule
`default_nettype wire

// ===== src/hrbd_core.sv =====
`default_nettype none
module hrbd_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             fire,
   input  wire logic [7:0]       rx_byte,
   input  wire logic             new_response,
   output hrbd_pkg::res_type     res
);
   import hrbd_pkg::*;

   phase_type              phase_ff,   phase_in;
   logic [1:0]             crlf_ff,    crlf_in;
   logic [4:0]             lkp_ff,     lkp_in;
   logic [4:0]             ckp_ff,     ckp_in;
   logic                   lfound_ff,  lfound_in;
   logic                   cfound_ff,  cfound_in;
   logic [COUNT_BITS-1:0]  acc_ff,     acc_in;
   logic [COUNT_BITS-1:0]  left_ff,    left_in;

   phase_type              ph_cur;
   logic [1:0]             crlf_cur;
   logic [4:0]             lkp_cur;
   logic [4:0]             ckp_cur;
   logic                   lfound_cur;
   logic                   cfound_cur;
   logic [COUNT_BITS-1:0]  acc_cur;
   logic [COUNT_BITS-1:0]  left_cur;
   logic [COUNT_BITS-1:0]  left_dec;
   logic [COUNT_BITS-1:0]  acc_sum;
   logic                   use_hex;
   digit_type              dec_d;
   digit_type              hex_d;
   crlf_type               cr;
   mode_type               mode;

   // new response clears everything before this beat is handled
   always_comb begin
      ph_cur     = new_response ? PH_HEADER : phase_ff;
      crlf_cur   = new_response ? 2'd0 : crlf_ff;
      lkp_cur    = new_response ? 5'd0 : lkp_ff;
      ckp_cur    = new_response ? 5'd0 : ckp_ff;
      lfound_cur = new_response ? 1'b0 : lfound_ff;
      cfound_cur = new_response ? 1'b0 : cfound_ff;
      acc_cur    = new_response ? '0 : acc_ff;
      left_cur   = new_response ? '0 : left_ff;
   end

   assign dec_d    = dec_value(rx_byte);
   assign hex_d    = hex_value(rx_byte);
   assign use_hex  = (ph_cur != PH_HEADER);
   assign left_dec = left_cur - COUNT_BITS'(1);

   hrbd_acc u_acc (
      .acc    (acc_cur),
      .is_hex (use_hex),
      .digit  (use_hex ? hex_d.val : dec_d.val),
      .sum    (acc_sum)
   );

   always_comb begin
      phase_in  = ph_cur;
      crlf_in   = crlf_cur;
      lkp_in    = lkp_cur;
      ckp_in    = ckp_cur;
      lfound_in = lfound_cur;
      cfound_in = cfound_cur;
      acc_in    = acc_cur;
      left_in   = left_cur;
      res       = '0;
      cr        = '0;
      mode      = MODE_NONE;

      case (ph_cur)
         PH_HEADER: begin
            if (lkp_cur < LEN_KEY_LEN) begin
               lkp_in = key_step(lkp_cur, len_key_byte(lkp_cur), len_key_byte(5'd0), rx_byte);
               if (lkp_in == LEN_KEY_LEN) begin
                  lfound_in = 1'b1;
                  acc_in    = '0;
               end
            end else if (lkp_cur == LEN_KEY_LEN) begin
               if (dec_d.ok) begin
                  acc_in = acc_sum;
               end else begin
                  lkp_in = LEN_VALUE_DONE;
               end
            end
            if (ckp_cur < CHK_KEY_LEN) begin
               ckp_in = key_step(ckp_cur, chk_key_byte(ckp_cur), chk_key_byte(5'd0), rx_byte);
               if (ckp_in == CHK_KEY_LEN) begin
                  cfound_in = 1'b1;
               end
            end
            cr      = crlf_next(crlf_cur, rx_byte, 1'b1);
            crlf_in = cr.cnt;
            if (lfound_in) begin
               mode = MODE_LENGTH;
            end else if (cfound_in) begin
               mode = MODE_CHUNKED;
            end
            if (cr.hit) begin
               if (lfound_in) begin
                  left_in = acc_in;
                  acc_in  = '0;
                  if (left_in == '0) begin
                     phase_in = PH_DONE;
                     res      = '{1'b1, 8'd0, 1'b0, 1'b1, mode};
                  end else begin
                     phase_in = PH_LEN_BODY;
                  end
               end else if (cfound_in) begin
                  acc_in   = '0;
                  phase_in = PH_SIZE_DIGITS;
               end else begin
                  phase_in = PH_DONE;
                  res      = '{1'b1, 8'd0, 1'b0, 1'b1, mode};
               end
            end
         end
         PH_LEN_BODY: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_DONE;
            end
            res = '{1'b1, rx_byte, 1'b1, (left_dec == '0), MODE_LENGTH};
         end
         PH_SIZE_DIGITS, PH_SIZE_TAIL: begin
            mode = lfound_cur ? MODE_LENGTH : MODE_CHUNKED;
            if (ph_cur == PH_SIZE_DIGITS) begin
               if (hex_d.ok) begin
                  acc_in = acc_sum;
               end else begin
                  phase_in = PH_SIZE_TAIL;
               end
            end
            cr      = crlf_next(crlf_cur, rx_byte, 1'b0);
            crlf_in = cr.cnt;
            if (cr.hit) begin
               if (acc_in == '0) begin
                  phase_in = PH_DONE;
                  res      = '{1'b1, 8'd0, 1'b0, 1'b1, mode};
               end else begin
                  left_in  = acc_in;
                  acc_in   = '0;
                  phase_in = PH_CHUNK_DATA;
               end
            end
         end
         PH_CHUNK_DATA: begin
            mode    = lfound_cur ? MODE_LENGTH : MODE_CHUNKED;
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_SKIP_CR;
            end
            res = '{1'b1, rx_byte, 1'b1, 1'b0, mode};
         end
         PH_SKIP_CR: begin
            phase_in = PH_SKIP_LF;
         end
         PH_SKIP_LF: begin
            phase_in = PH_SIZE_DIGITS;
            acc_in   = '0;
            crlf_in  = 2'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         crlf_ff   <= 2'd0;
         lkp_ff    <= 5'd0;
         ckp_ff    <= 5'd0;
         lfound_ff <= 1'b0;
         cfound_ff <= 1'b0;
         acc_ff    <= '0;
         left_ff   <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         crlf_ff   <= crlf_in;
         lkp_ff    <= lkp_in;
         ckp_ff    <= ckp_in;
         lfound_ff <= lfound_in;
         cfound_ff <= cfound_in;
         acc_ff    <= acc_in;
         left_ff   <= left_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/http_response_body_deframer_top.sv =====
// http response body deframer
// req channel: one response byte per beat in req_tdata; req_tuser set on the
// first byte of a new response clears all parser state before that byte.
// rsp channel: at most one beat per request beat. rsp_tdata is a body byte,
// rsp_tuser carries has_byte and the framing mode, rsp_tlast marks the last
// beat of the body. an empty body, or the end of a chunked body, gives a single
// beat with has_byte low and rsp_tlast high.
// the response beat is registered: it is valid in the cycle after the request beat.
// throughput: one byte per cycle; the parser state and the result register
// are updated in the same cycle, so req_tready stays high while the result
// register is empty or being taken.
// when the receiver holds rsp_tready low with a beat waiting, req_tready
// drops and the waiting beat holds until taken.
// reset returns the parser to the header phase and empties the result
// register; bytes after the end of a body give no beats until a new response.
`default_nettype none
module http_response_body_deframer_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // rx_byte[7:0]
   input  wire logic       req_tuser,   // new_response
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // body_byte[7:0]
   output logic [2:0]      rsp_tuser,   // framing_mode[1:0], has_byte
   output logic            rsp_tlast    // end_of_body
);
   import hrbd_pkg::*;

   logic       fire;
   res_type    res;
   logic       vld_ff,  vld_in;
   logic [7:0] data_ff;
   logic [2:0] user_ff;
   logic       last_ff;

   assign req_tready = !vld_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;

   hrbd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .rx_byte      (req_tdata),
      .new_response (req_tuser),
      .res          (res)
   );

   always_comb begin
      vld_in = vld_ff && !rsp_tready;
      if (fire) begin
         vld_in = res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= res.body_byte;
         user_ff <= {res.framing_mode, res.has_byte};
         last_ff <= res.end_of_body;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule
`default_nettype wire

// ===== src/hrbd_checker.sv =====
`default_nettype none
module hrbd_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tready,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata,
   input wire logic [2:0] rsp_tuser,
   input wire logic       rsp_tlast
);
   import hrbd_pkg::*;

   // stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("rsp beat changed while stalled");

   // stall propagates back to the request side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req accepted while rsp stalled");

   // a beat without a byte is always the end marker with zero data
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && (rsp_tdata == 8'd0))
      else $error("bad end marker");

   // with no framing found only the end marker comes out
   a_no_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] == MODE_NONE) |-> !rsp_tuser[0] && rsp_tlast)
      else $error("body byte without framing");

endmodule

bind http_response_body_deframer_top hrbd_checker u_hrbd_checker (.*);
`default_nettype wire
